>>> hdl/cmg_pkg.sv
// Package for the cone mesh generator: sizes, register indexes, geometry record
// and the elaboration-time builders for the sine and reciprocal tables.
// No dependencies.
package cmg_pkg;

    localparam int MAX_SLICES       = 256;
    localparam int MAX_STACKS       = 256;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);

    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_DEPTH = (MAX_SLICES > MAX_STACKS) ? MAX_SLICES : MAX_STACKS;

    localparam int IDX_W  = 17;
    localparam int POS_W  = 17;
    localparam int Z_W    = 16;
    localparam int TRIG_W = 18;
    localparam int CNT_W  = 9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 3'd3;

    localparam logic [15:0]      RADIUS_RST = 16'd256;
    localparam logic [15:0]      HEIGHT_RST = 16'd256;
    localparam logic [CNT_W-1:0] SLICES_RST = 9'd16;
    localparam logic [CNT_W-1:0] STACKS_RST = 9'd4;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_FACE   = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef t_trig t_sine_tab [SINE_TABLE_DEPTH];
    typedef logic [RECIP_W-1:0] t_recip_tab [RECIP_DEPTH];

    typedef struct packed {
        logic [15:0]        radius;
        logic [15:0]        height;
        logic [CNT_W-1:0]   s;
        logic [CNT_W-1:0]   st;
        logic [IDX_W-1:0]   rv;
        logic [IDX_W-1:0]   side;
        logic [IDX_W:0]     flim;
        logic [RECIP_W-1:0] rs;
        logic [RECIP_W-1:0] rst;
    } t_geom;

    // ceil(2^RECIP_SHIFT / d), entry d-1
    function automatic t_recip_tab build_recip_tab();
        t_recip_tab tab;
        for (int d = 0; d < RECIP_DEPTH; d++) begin
            tab[d] = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(d)) / 64'(d + 1));
        end
        return tab;
    endfunction

    // Q16 sine over one turn; Q30 Taylor series per quadrant
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab          tab;
        logic [63:0]        p4;
        logic [63:0]        quad;
        logic [63:0]        rem;
        logic [63:0]        t;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        for (int p = 0; p < SINE_TABLE_DEPTH; p++) begin
            p4   = 64'(4 * p);
            quad = p4 / SINE_TABLE_DEPTH;
            rem  = p4 % SINE_TABLE_DEPTH;
            t    = rem * HALF_PI_Q30 / SINE_TABLE_DEPTH;
            x2   = (t * t) >> 30;
            term = quad[0] ? ONE_Q30 : t;
            sum  = signed'(term);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                case (k)
                    1:       term = quad[0] ? term / 64'd2  : term / 64'd6;
                    2:       term = quad[0] ? term / 64'd12 : term / 64'd20;
                    3:       term = quad[0] ? term / 64'd30 : term / 64'd42;
                    4:       term = quad[0] ? term / 64'd56 : term / 64'd72;
                    5:       term = quad[0] ? term / 64'd90 : term / 64'd110;
                    default: term = quad[0] ? term / 64'd132 : term / 64'd156;
                endcase
                if ((k % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > signed'(ONE_Q30)) begin
                sum = signed'(ONE_Q30);
            end
            v = (unsigned'(sum) + 64'd8192) >> 14;
            tab[p] = (quad >= 64'd2) ? -TRIG_W'(v) : TRIG_W'(v);
        end
        return tab;
    endfunction

endpackage

>>> hdl/cmg_if.sv
// Channel interfaces of the cone mesh generator: query input, result output
// and register write. Depends on cmg_pkg.
interface cmg_in_if import cmg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [IDX_W-1:0] item_index;
    modport source (output valid, op, item_index, input ready);
    modport sink (input valid, op, item_index, output ready);
endinterface

interface cmg_out_if import cmg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [Z_W-1:0]          pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic                    status;
    modport source (output valid, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, status,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, status,
                  output ready);
endinterface

interface cmg_cfg_if import cmg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/cmg_config.sv
// Register file and derived geometry (clamped counts, vertex/face limits,
// reciprocals) of the cone mesh generator. Depends on cmg_pkg, cmg_if.
module cmg_config import cmg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmg_cfg_if.sink   i_cfg,
    output t_geom     o_geom,
    output logic      o_live
);
    localparam t_recip_tab RECIP_TAB = build_recip_tab();

    logic [15:0]      r_radius;
    logic [15:0]      r_height;
    logic [CNT_W-1:0] r_slices;
    logic [CNT_W-1:0] r_stacks;
    logic             r_live;
    t_geom            r_geom;
    t_geom            n_geom;

    logic [CNT_W-1:0]   s;
    logic [CNT_W-1:0]   st;
    logic [2*CNT_W-1:0] ring;
    logic [2*CNT_W-1:0] side_half;

    always_comb begin
        s = r_slices;
        if (s < CNT_W'(3)) s = CNT_W'(3);
        if (s > CNT_W'(MAX_SLICES)) s = CNT_W'(MAX_SLICES);
        st = r_stacks;
        if (st < CNT_W'(1)) st = CNT_W'(1);
        if (st > CNT_W'(MAX_STACKS)) st = CNT_W'(MAX_STACKS);
        ring      = s * st;
        side_half = s * (st - CNT_W'(1));
        n_geom.radius = r_radius;
        n_geom.height = r_height;
        n_geom.s      = s;
        n_geom.st     = st;
        n_geom.rv     = IDX_W'(ring);
        n_geom.side   = IDX_W'({side_half, 1'b0});
        n_geom.flim   = (IDX_W+1)'({ring, 1'b0});
        n_geom.rs     = RECIP_TAB[7'(0) + 8'(s - CNT_W'(1))];
        n_geom.rst    = RECIP_TAB[7'(0) + 8'(st - CNT_W'(1))];
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_height <= HEIGHT_RST;
            r_slices <= SLICES_RST;
            r_stacks <= STACKS_RST;
            r_live   <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_cfg.valid && r_live) begin
                case (i_cfg.index)
                    CFG_RADIUS: r_radius <= i_cfg.data;
                    CFG_HEIGHT: r_height <= i_cfg.data;
                    CFG_SLICES: r_slices <= i_cfg.data[CNT_W-1:0];
                    CFG_STACKS: r_stacks <= i_cfg.data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign i_cfg.ready = r_live;
    assign o_geom      = r_geom;
    assign o_live      = r_live;
endmodule

>>> hdl/cmg_sine_rom.sv
// Dual-read sine ROM with registered outputs, Q16 signed entries.
// Depends on cmg_pkg.
module cmg_sine_rom import cmg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SINE_AW-1:0] i_addr_a,
    input  logic [SINE_AW-1:0] i_addr_b,
    output t_trig              o_data_a,
    output t_trig              o_data_b
);
    localparam t_sine_tab SINE_TAB = build_sine_tab();

    t_trig r_data_a;
    t_trig r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SINE_TAB[i_addr_a];
            r_data_b <= SINE_TAB[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;
endmodule

>>> hdl/cmg_pipe.sv
// Nine-stage query pipeline: index split by reciprocal, phase, ROM lookup,
// scaling and rounding, face corners. Depends on cmg_pkg, cmg_if, cmg_sine_rom.
module cmg_pipe import cmg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_geom     i_geom,
    input  logic      i_live,
    cmg_in_if.sink    i_in,
    cmg_out_if.source o_out
);
    typedef enum logic [2:0] {
        K_NONE, K_RING, K_APEX, K_SIDE, K_TOP, K_BASE
    } t_kind;

    localparam int JN_W = 8 + SINE_AW + 1;
    localparam int P_W  = SINE_AW + 1;

    logic [9:1] r_v;
    logic [9:1] en;

    // stage 1
    logic             r1_op;
    logic [IDX_W-1:0] r1_n;
    // stage 2
    t_kind            r2_kind, n2_kind;
    logic             r2_oor, n2_oor;
    logic [IDX_W-1:0] r2_n, r2_k, n2_k;
    logic [IDX_W-1:0] r2_est, n2_est;
    logic [IDX_W+RECIP_W-1:0] prod2;
    // stage 3
    t_kind            r3_kind;
    logic             r3_oor;
    logic [IDX_W-1:0] r3_n, r3_k;
    logic [7:0]       r3_i, r3_j, n3_i, n3_j;
    logic [IDX_W+CNT_W-1:0] prod3, rem3;
    // stage 4
    t_kind            r4_kind;
    logic             r4_oor;
    logic [JN_W-1:0]  r4_jnum, n4_jnum;
    logic [P_W-1:0]   r4_estp, n4_estp;
    logic [23:0]      r4_rr, n4_rr, r4_zn, n4_zn;
    logic [IDX_W-1:0] r4_ca, r4_cb, r4_cc, n4_ca, n4_cb, n4_cc;
    logic [JN_W+RECIP_W-1:0] prod4;
    logic [IDX_W-1:0] lo4, hi4, m4, mb4;
    logic [CNT_W-1:0] jn4;
    // stage 5
    t_kind            r5_kind;
    logic             r5_oor;
    logic [SINE_AW-1:0] r5_p, n5_p;
    logic [23:0]      r5_rr, r5_zn;
    logic [IDX_W-1:0] r5_estz, n5_estz;
    logic [IDX_W-1:0] r5_ca, r5_cb, r5_cc;
    logic [P_W+CNT_W-1:0] chk5;
    logic [24+RECIP_W-1:0] prod5;
    // stage 6
    t_kind            r6_kind;
    logic             r6_oor;
    logic [23:0]      r6_rr;
    logic [Z_W-1:0]   r6_z, n6_z;
    logic [IDX_W-1:0] r6_ca, r6_cb, r6_cc;
    logic [IDX_W+CNT_W-1:0] chk6;
    t_trig            sin6, cos6;
    // stage 7
    t_kind            r7_kind;
    logic             r7_oor;
    logic [Z_W-1:0]   r7_z;
    logic [IDX_W-1:0] r7_ca, r7_cb, r7_cc;
    logic [24:0]      r7_ux, r7_uy, n7_ux, n7_uy;
    logic             r7_negx, r7_negy;
    logic [16:0]      magx7, magy7;
    logic [41:0]      sumx7, sumy7;
    // stage 8
    t_kind            r8_kind;
    logic             r8_oor;
    logic [Z_W-1:0]   r8_z;
    logic [IDX_W-1:0] r8_ca, r8_cb, r8_cc;
    logic [24:0]      r8_ux, r8_uy;
    logic             r8_negx, r8_negy;
    logic [16:0]      r8_ex, r8_ey, n8_ex, n8_ey;
    logic [25+RECIP_W-1:0] prodx8, prody8;
    // stage 9 (output)
    logic signed [POS_W-1:0] r9_x, r9_y, n9_x, n9_y;
    logic [Z_W-1:0]   r9_z, n9_z;
    logic [IDX_W-1:0] r9_ca, r9_cb, r9_cc, n9_ca, n9_cb, n9_cc;
    logic             r9_st, n9_st;
    logic [25:0]      chkx9, chky9;
    logic [16:0]      qx9, qy9;

    always_comb begin
        en[9] = !r_v[9] || o_out.ready;
        for (int k = 8; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign i_in.ready = en[1] && i_live;

    // stage 2: range check, kind, quotient estimate
    always_comb begin
        n2_k = (r1_op == OP_FACE) ? {1'b0, r1_n[IDX_W-1:1]} : r1_n;
        if (r1_op == OP_FACE) begin
            n2_oor = {1'b0, r1_n} >= i_geom.flim;
            if (r1_n < i_geom.side) begin
                n2_kind = K_SIDE;
            end else if ({1'b0, r1_n} < {1'b0, i_geom.side} + (IDX_W+1)'(i_geom.s)) begin
                n2_kind = K_TOP;
            end else begin
                n2_kind = K_BASE;
            end
        end else begin
            n2_oor = {1'b0, r1_n} >= {1'b0, i_geom.rv} + (IDX_W+1)'(2);
            if (r1_n == i_geom.rv) begin
                n2_kind = K_APEX;
            end else if (r1_n < i_geom.rv) begin
                n2_kind = K_RING;
            end else begin
                n2_kind = K_NONE;
            end
        end
        prod2  = n2_k * i_geom.rs;
        n2_est = prod2[RECIP_SHIFT +: IDX_W];
    end

    // stage 3: correct quotient, ring and column
    always_comb begin
        prod3 = r2_est * i_geom.s;
        if (prod3 > (IDX_W+CNT_W)'(r2_k)) begin
            rem3 = (IDX_W+CNT_W)'(r2_k) + (IDX_W+CNT_W)'(i_geom.s) - prod3;
            n3_i = 8'(r2_est - IDX_W'(1));
        end else begin
            rem3 = (IDX_W+CNT_W)'(r2_k) - prod3;
            n3_i = r2_est[7:0];
        end
        n3_j = rem3[7:0];
    end

    // stage 4: phase estimate, radius and height numerators, face corners
    always_comb begin
        n4_jnum = (JN_W'(r3_j) << SINE_AW) + JN_W'(i_geom.s >> 1);
        prod4   = n4_jnum * i_geom.rs;
        n4_estp = prod4[RECIP_SHIFT +: P_W];
        n4_rr   = 24'(i_geom.radius * (i_geom.st - CNT_W'(r3_i)));
        n4_zn   = 24'(r3_i * i_geom.height) + 24'(i_geom.st >> 1);

        lo4 = r3_k - IDX_W'(r3_j);
        hi4 = lo4 + IDX_W'(i_geom.s);
        jn4 = (CNT_W'(r3_j) + CNT_W'(1) == i_geom.s) ? '0 : CNT_W'(r3_j) + CNT_W'(1);
        m4  = r3_n - i_geom.side;
        mb4 = m4 - IDX_W'(i_geom.s);
        n4_ca = '0;
        n4_cb = '0;
        n4_cc = '0;
        case (r3_kind)
            K_SIDE: begin
                if (!r3_n[0]) begin
                    n4_ca = lo4 + IDX_W'(jn4);
                    n4_cb = r3_k;
                end else begin
                    n4_ca = r3_k;
                    n4_cb = hi4 + IDX_W'(r3_j);
                end
                n4_cc = hi4 + IDX_W'(jn4);
            end
            K_TOP: begin
                n4_ca = i_geom.rv;
                if (m4 == IDX_W'(i_geom.s) - IDX_W'(1)) begin
                    n4_cb = i_geom.rv - IDX_W'(i_geom.s);
                    n4_cc = i_geom.rv - IDX_W'(1);
                end else begin
                    n4_cb = i_geom.rv - m4 - IDX_W'(1);
                    n4_cc = i_geom.rv - m4 - IDX_W'(2);
                end
            end
            K_BASE: begin
                n4_cb = i_geom.rv + IDX_W'(1);
                if (mb4 == IDX_W'(i_geom.s) - IDX_W'(1)) begin
                    n4_ca = '0;
                    n4_cc = IDX_W'(i_geom.s) - IDX_W'(1);
                end else begin
                    n4_ca = mb4 + IDX_W'(1);
                    n4_cc = mb4;
                end
            end
            default: ;
        endcase
    end

    // stage 5: correct phase, height quotient estimate
    always_comb begin
        chk5 = r4_estp * i_geom.s;
        if (chk5 > (P_W+CNT_W)'(r4_jnum)) begin
            n5_p = SINE_AW'(r4_estp - P_W'(1));
        end else begin
            n5_p = r4_estp[SINE_AW-1:0];
        end
        prod5   = r4_zn * i_geom.rst;
        n5_estz = prod5[RECIP_SHIFT +: IDX_W];
    end

    cmg_sine_rom u_rom (
        .i_clk    (i_clk),
        .i_en     (en[6]),
        .i_addr_a (r5_p),
        .i_addr_b (r5_p + SINE_AW'(SINE_TABLE_DEPTH / 4)),
        .o_data_a (sin6),
        .o_data_b (cos6)
    );

    // stage 6: height correction
    always_comb begin
        chk6 = r5_estz * i_geom.st;
        if (chk6 > (IDX_W+CNT_W)'(r5_zn)) begin
            n6_z = Z_W'(r5_estz - IDX_W'(1));
        end else begin
            n6_z = r5_estz[Z_W-1:0];
        end
    end

    // stage 7: scale magnitudes, add half of the divisor
    always_comb begin
        magx7 = sin6[TRIG_W-1] ? 17'(-sin6) : 17'(sin6);
        magy7 = cos6[TRIG_W-1] ? 17'(-cos6) : 17'(cos6);
        sumx7 = 42'(r6_rr * magx7) + 42'({i_geom.st, 15'b0});
        sumy7 = 42'(r6_rr * magy7) + 42'({i_geom.st, 15'b0});
        n7_ux = sumx7[16 +: 25];
        n7_uy = sumy7[16 +: 25];
    end

    // stage 8: coordinate quotient estimate
    always_comb begin
        prodx8 = r7_ux * i_geom.rst;
        prody8 = r7_uy * i_geom.rst;
        n8_ex  = prodx8[RECIP_SHIFT +: 17];
        n8_ey  = prody8[RECIP_SHIFT +: 17];
    end

    // stage 9: correction, sign and field selection
    always_comb begin
        chkx9 = r8_ex * i_geom.st;
        chky9 = r8_ey * i_geom.st;
        qx9 = (chkx9 > 26'(r8_ux)) ? r8_ex - 17'd1 : r8_ex;
        qy9 = (chky9 > 26'(r8_uy)) ? r8_ey - 17'd1 : r8_ey;
        n9_x  = '0;
        n9_y  = '0;
        n9_z  = '0;
        n9_ca = '0;
        n9_cb = '0;
        n9_cc = '0;
        n9_st = r8_oor ? STATUS_RANGE : STATUS_OK;
        if (!r8_oor) begin
            case (r8_kind)
                K_RING: begin
                    n9_x = r8_negx ? -signed'(qx9) : signed'(qx9);
                    n9_y = r8_negy ? -signed'(qy9) : signed'(qy9);
                    n9_z = r8_z;
                end
                K_APEX: n9_z = i_geom.height;
                K_SIDE, K_TOP, K_BASE: begin
                    n9_ca = r8_ca;
                    n9_cb = r8_cb;
                    n9_cc = r8_cc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_in.valid && i_live;
            for (int k = 2; k <= 9; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
        if (en[1]) begin
            r1_op <= i_in.op;
            r1_n  <= i_in.item_index;
        end
        if (en[2]) begin
            r2_kind <= n2_kind;
            r2_oor  <= n2_oor;
            r2_n    <= r1_n;
            r2_k    <= n2_k;
            r2_est  <= n2_est;
        end
        if (en[3]) begin
            r3_kind <= r2_kind;
            r3_oor  <= r2_oor;
            r3_n    <= r2_n;
            r3_k    <= r2_k;
            r3_i    <= n3_i;
            r3_j    <= n3_j;
        end
        if (en[4]) begin
            r4_kind <= r3_kind;
            r4_oor  <= r3_oor;
            r4_jnum <= n4_jnum;
            r4_estp <= n4_estp;
            r4_rr   <= n4_rr;
            r4_zn   <= n4_zn;
            r4_ca   <= n4_ca;
            r4_cb   <= n4_cb;
            r4_cc   <= n4_cc;
        end
        if (en[5]) begin
            r5_kind <= r4_kind;
            r5_oor  <= r4_oor;
            r5_p    <= n5_p;
            r5_rr   <= r4_rr;
            r5_zn   <= r4_zn;
            r5_estz <= n5_estz;
            r5_ca   <= r4_ca;
            r5_cb   <= r4_cb;
            r5_cc   <= r4_cc;
        end
        if (en[6]) begin
            r6_kind <= r5_kind;
            r6_oor  <= r5_oor;
            r6_rr   <= r5_rr;
            r6_z    <= n6_z;
            r6_ca   <= r5_ca;
            r6_cb   <= r5_cb;
            r6_cc   <= r5_cc;
        end
        if (en[7]) begin
            r7_kind <= r6_kind;
            r7_oor  <= r6_oor;
            r7_z    <= r6_z;
            r7_ca   <= r6_ca;
            r7_cb   <= r6_cb;
            r7_cc   <= r6_cc;
            r7_ux   <= n7_ux;
            r7_uy   <= n7_uy;
            r7_negx <= sin6[TRIG_W-1];
            r7_negy <= cos6[TRIG_W-1];
        end
        if (en[8]) begin
            r8_kind <= r7_kind;
            r8_oor  <= r7_oor;
            r8_z    <= r7_z;
            r8_ca   <= r7_ca;
            r8_cb   <= r7_cb;
            r8_cc   <= r7_cc;
            r8_ux   <= r7_ux;
            r8_uy   <= r7_uy;
            r8_negx <= r7_negx;
            r8_negy <= r7_negy;
            r8_ex   <= n8_ex;
            r8_ey   <= n8_ey;
        end
        if (en[9]) begin
            r9_x  <= n9_x;
            r9_y  <= n9_y;
            r9_z  <= n9_z;
            r9_ca <= n9_ca;
            r9_cb <= n9_cb;
            r9_cc <= n9_cc;
            r9_st <= n9_st;
        end
    end

    assign o_out.valid    = r_v[9];
    assign o_out.pos_x    = r9_x;
    assign o_out.pos_y    = r9_y;
    assign o_out.pos_z    = r9_z;
    assign o_out.corner_a = r9_ca;
    assign o_out.corner_b = r9_cb;
    assign o_out.corner_c = r9_cc;
    assign o_out.status   = r9_st;
endmodule

>>> hdl/cone_mesh_generator.sv
// Top level of the cone mesh generator: register port plus query pipeline.
// Depends on cmg_pkg, cmg_if, cmg_config, cmg_pipe.
//
// Usage:
//   i_cfg  - register writes (radius, height, slice_count, stack_count), one
//            transaction per cycle; the user writes only while no query is in flight (not enforced).
//   i_in   - queries: op selects vertex or face, item_index picks it.
//   o_out  - one result transaction per query, in query order; status
//            flags an index past the vertex or face count.
// A query passes the nine register stages from the input register to the output
// register (reciprocal divide, phase, sine ROM, scaling, rounding correction).
// Throughput: one query per cycle unless a stalled output has filled every stage.
// Reset: registers return to radius 256, height 256, 16 slices, 4 stacks;
// the pipeline empties and both ready lines stay low until the live register
// is set after reset is released.
// Stall: a held result keeps its stage; earlier stages keep filling, and
// i_in.ready drops only once every stage holds a query.
module cone_mesh_generator import cmg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmg_cfg_if.sink   i_cfg,
    cmg_in_if.sink    i_in,
    cmg_out_if.source o_out
);
    t_geom geom;
    logic  live;

    cmg_config u_config (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_geom  (geom),
        .o_live  (live)
    );

    cmg_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_live  (live),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

>>> hdl/cmg_checker.sv
// Port-level checks for the cone mesh generator, bound to the top level.
// Depends on cmg_pkg and cone_mesh_generator.
module cmg_checker import cmg_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [POS_W-1:0] i_pos_x,
    input logic signed [POS_W-1:0] i_pos_y,
    input logic [Z_W-1:0]          i_pos_z,
    input logic [IDX_W-1:0]        i_corner_a,
    input logic [IDX_W-1:0]        i_corner_b,
    input logic [IDX_W-1:0]        i_corner_c,
    input logic                    i_status
);
    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STATUS_RANGE |->
            i_pos_x == 0 && i_pos_y == 0 && i_pos_z == 0 &&
            i_corner_a == 0 && i_corner_b == 0 && i_corner_c == 0)
        else $error("range error result carries data");

    a_face_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_corner_a != 0 || i_corner_b != 0 || i_corner_c != 0) |->
            i_pos_x == 0 && i_pos_y == 0 && i_pos_z == 0)
        else $error("face result carries a position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output drains");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_pos_z) &&
            $stable(i_corner_a) && $stable(i_corner_b) && $stable(i_corner_c) &&
            $stable(i_status))
        else $error("stalled result changed");
endmodule

bind cone_mesh_generator cmg_checker u_cmg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos_x     (o_out.pos_x),
    .i_pos_y     (o_out.pos_y),
    .i_pos_z     (o_out.pos_z),
    .i_corner_a  (o_out.corner_a),
    .i_corner_b  (o_out.corner_b),
    .i_corner_c  (o_out.corner_c),
    .i_status    (o_out.status)
);
